FILE: design/modular_inverse_ext_euclid_defines.svh
// Assertion macros shared by the modular inverse design files.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on aclk, off during reset.
`define MIE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define MIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MIE_ASSERT_NOW(label, ante, cons)
`define MIE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/mie_pkg.sv
// Shared types and constants for the modular inverse block.
// Depends on nothing; used by mie_div_unit and modular_inverse_ext_euclid.
package mie_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned CountWidth = $clog2(WordWidth);

    typedef logic [WordWidth-1:0] word_t;

    // Input word: the number and its modulus.
    typedef struct packed {
        word_t value;
        word_t modulus;
    } in_word_t;

    // Result word.
    typedef struct packed {
        word_t inverse;
        word_t gcd_result;
        logic  no_inverse;
    } out_word_t;

    // Status of the shared divide unit.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_REDUCE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

FILE: design/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block: sequencer, Euclid state and result register.
// Depends on mie_pkg, mie_div_unit and modular_inverse_ext_euclid_defines.svh.
//
// Usage: present a word {value, modulus} on s_data with s_valid; it is taken
// when s_valid and s_ready are both high. The block runs the extended
// Euclidean algorithm and returns one word {inverse, gcd_result, no_inverse}
// on m_data with m_valid, taken when m_ready is high.
// The run time grows with the number of quotient steps, at most 46 for
// 32-bit operands. Each quotient step passes through the check state, the
// shared bit-serial divide unit and its done pulse. One word is processed
// at a time: s_ready is high only when the sequencer is idle, so a new word
// is taken only once the last one has been loaded into the output register.
// The result sits in an output register, so the next word is accepted while
// a finished result still waits; a stalled receiver holds m_data steady and
// only stops the sequencer at its final load.
// Reset (aresetn low at a clock edge) returns the sequencer to idle and
// drops m_valid; any word in flight is lost.
`include "modular_inverse_ext_euclid_defines.svh"

module modular_inverse_ext_euclid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mie_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mie_pkg::out_word_t  m_data
);
    import mie_pkg::*;

    state_t      state_reg, state_next;
    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    word_t       ca_reg, ca_next;
    word_t       cb_reg, cb_next;
    logic        na_reg, na_next;
    logic        nb_reg, nb_next;
    word_t       mod_reg, mod_next;
    word_t       red_reg, red_next;
    logic        flag_reg, flag_next;
    out_word_t   out_reg, out_next;
    logic        m_valid_reg, m_valid_next;
    logic        div_start;
    word_t       div_rem;
    word_t       div_prod;
    div_status_t div_status;
    logic        load_out;

    // Shared divide unit: q = a / b, remainder, and q * cb.
    mie_div_unit u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .coef      (cb_reg),
        .remainder (div_rem),
        .product   (div_prod),
        .status    (div_status)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_CHECK) && (b_reg != '0);
    assign load_out  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // Sequencer and Euclid state update.
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        mod_next   = mod_reg;
        red_next   = red_reg;
        flag_next  = flag_reg;
        out_next   = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next     = s_data.value;
                    b_next     = s_data.modulus;
                    mod_next   = s_data.modulus;
                    ca_next    = word_t'(1);
                    cb_next    = '0;
                    na_next    = 1'b0;
                    nb_next    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (b_reg == '0) begin
                    state_next = ST_REDUCE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // Shift the remainder and coefficient sequences by one step.
                if (div_status.done) begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    ca_next    = cb_reg;
                    cb_next    = ca_reg + div_prod;
                    na_next    = nb_reg;
                    nb_next    = na_reg;
                    state_next = ST_CHECK;
                end
            end
            ST_REDUCE: begin
                // The coefficient magnitude never exceeds a nonzero modulus.
                flag_next  = (mod_reg == '0) || (a_reg != word_t'(1));
                red_next   = (ca_reg >= mod_reg) ? ca_reg - mod_reg : ca_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) begin
                    out_next.gcd_result = a_reg;
                    out_next.no_inverse = flag_reg;
                    if (flag_reg) begin
                        out_next.inverse = '0;
                    end else if (na_reg && (red_reg != '0)) begin
                        out_next.inverse = mod_reg - red_reg;
                    end else begin
                        out_next.inverse = red_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the receiver takes the word.
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        mod_reg  <= mod_next;
        red_reg  <= red_next;
        flag_reg <= flag_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A finished division always hands back to the zero check.
    `MIE_ASSERT_NEXT(a_div_to_check, (state_reg == ST_DIV) && div_status.done, state_reg == ST_CHECK)
    // A zero remainder ends the loop.
    `MIE_ASSERT_NEXT(a_zero_ends, (state_reg == ST_CHECK) && (b_reg == '0), state_reg == ST_REDUCE)
    // The divide unit only runs while the sequencer waits on it.
    `MIE_ASSERT_NOW(a_div_owned, div_status.busy, state_reg == ST_DIV)
    // A clear flag means the loaded gcd is one.
    `MIE_ASSERT_NEXT(a_gcd_one, load_out && !flag_reg, m_data.gcd_result == word_t'(1))
    // A flagged result carries a zero inverse.
    `MIE_ASSERT_NOW(a_flag_zero, m_valid && m_data.no_inverse, m_data.inverse == '0)

endmodule

FILE: design/mie_div_unit.sv
// Iterative restoring divider that also accumulates quotient times a coefficient.
// Depends on mie_pkg and modular_inverse_ext_euclid_defines.svh.
`include "modular_inverse_ext_euclid_defines.svh"

module mie_div_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  mie_pkg::word_t      dividend,
    input  mie_pkg::word_t      divisor,
    input  mie_pkg::word_t      coef,
    output mie_pkg::word_t      remainder,
    output mie_pkg::word_t      product,
    output mie_pkg::div_status_t status
);
    import mie_pkg::*;

    word_t                 rem_reg, rem_next;
    word_t                 dvd_reg, dvd_next;
    word_t                 dvs_reg, dvs_next;
    word_t                 coef_reg, coef_next;
    word_t                 acc_reg, acc_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [WordWidth:0]    cand;
    logic [WordWidth:0]    diff;
    logic                  ge;

    // One quotient bit per cycle: shift in the next dividend bit and trial-subtract.
    // The partial remainder stays below the divisor, so a borrow out of the
    // top bit means the trial failed.
    always_comb begin
        cand = {rem_reg, dvd_reg[WordWidth-1]};
        diff = cand - {1'b0, dvs_reg};
        ge   = !diff[WordWidth];
    end

    // Step and start control.
    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        coef_next = coef_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            coef_next = coef;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[WordWidth-1:0] : cand[WordWidth-1:0];
            dvd_next = {dvd_reg[WordWidth-2:0], 1'b0};
            // Horner form of quotient times coefficient, MSB first.
            acc_next = {acc_reg[WordWidth-2:0], 1'b0} + (ge ? coef_reg : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CountWidth'(WordWidth - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
    end

    assign remainder   = rem_reg;
    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // A new division never starts over a running one.
    `MIE_ASSERT_NOW(a_no_restart, start, !busy_reg)
    // The sequencer never divides by zero.
    `MIE_ASSERT_NOW(a_divisor_nonzero, start, divisor != '0)
    // The partial remainder stays below the divisor while running.
    `MIE_ASSERT_NOW(a_rem_bound, busy_reg, rem_reg < dvs_reg)
    // Done is a single-cycle pulse and follows the last step.
    `MIE_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && !busy_reg)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the extended Euclidean modular inverse block.
// Depends on mie_pkg and modular_inverse_ext_euclid; words are predicted in-line.
module tb_top;

    localparam int unsigned WW          = mie_pkg::WordWidth;
    localparam int          CYCLE_LIMIT = 2_500_000;
    localparam int          DRAIN_WAIT  = 1700;
    localparam int          HOLD_CYCLES = 5000;
    localparam int          HOLD_AFTER  = 120;
    localparam int          RANDOM_WORDS = 350;

    typedef struct {
        mie_pkg::in_word_t  operands;
        mie_pkg::out_word_t result;
    } inverse_check_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mie_pkg::in_word_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mie_pkg::out_word_t  m_data;

    mie_pkg::in_word_t   operand_queue[$];
    inverse_check_t      expected_inverses[$];
    int                  mismatch_count = 0;
    int                  words_sent = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  pattern_left = 0;
    int                  pattern_mode = 0;
    int                  hold_left = 0;
    logic                hold_done = 1'b0;
    int                  cycle_count = 0;

    modular_inverse_ext_euclid u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Extended Euclid on the pair, with each Bezout coefficient held as a
    // magnitude and a sign. Intermediates are double width for safety.
    function automatic mie_pkg::out_word_t inverse_of(mie_pkg::in_word_t operands);
        logic [2*WW-1:0]    prev_rem;
        logic [2*WW-1:0]    cur_rem;
        logic [2*WW-1:0]    prev_mag;
        logic [2*WW-1:0]    cur_mag;
        logic [2*WW-1:0]    quot;
        logic [2*WW-1:0]    rem;
        logic [2*WW-1:0]    next_mag;
        logic [2*WW-1:0]    reduced;
        logic               prev_neg;
        logic               cur_neg;
        logic               next_neg;
        mie_pkg::out_word_t res;
        prev_rem = operands.value;
        cur_rem  = operands.modulus;
        prev_mag = 1;
        cur_mag  = 0;
        prev_neg = 1'b0;
        cur_neg  = 1'b1;
        while (cur_rem != 0) begin
            quot     = prev_rem / cur_rem;
            rem      = prev_rem - quot * cur_rem;
            next_mag = prev_mag + quot * cur_mag;
            next_neg = prev_neg;
            prev_rem = cur_rem;
            prev_mag = cur_mag;
            prev_neg = cur_neg;
            cur_rem  = rem;
            cur_mag  = next_mag;
            cur_neg  = next_neg;
        end
        res.gcd_result = prev_rem[WW-1:0];
        res.no_inverse = (operands.modulus == 0) || (prev_rem != 1);
        res.inverse    = '0;
        if (!res.no_inverse) begin
            // A negative coefficient folds up into the range; a zero stays zero.
            reduced = prev_mag % operands.modulus;
            if (prev_neg && reduced != 0) begin
                res.inverse = operands.modulus - reduced[WW-1:0];
            end else begin
                res.inverse = reduced[WW-1:0];
            end
        end
        return res;
    endfunction

    function automatic mie_pkg::in_word_t operand_pair(mie_pkg::word_t value,
                                                       mie_pkg::word_t modulus);
        mie_pkg::in_word_t w;
        w.value   = value;
        w.modulus = modulus;
        return w;
    endfunction

    // Random operands, weighted toward coprime pairs that reach the long
    // remainder chains, with shared factors, zeros and tiny moduli mixed in.
    function automatic mie_pkg::in_word_t random_operands();
        mie_pkg::word_t value;
        mie_pkg::word_t modulus;
        mie_pkg::word_t factor;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                value   = $urandom;
                modulus = $urandom;
            end
            3, 4: begin
                value   = $urandom;
                modulus = $urandom | 32'd1;
            end
            5: begin
                value   = $urandom_range(0, 300);
                modulus = $urandom_range(0, 300);
            end
            6: begin
                value   = $urandom;
                modulus = $urandom_range(0, 1);
            end
            7: begin
                factor  = $urandom_range(2, 1000);
                value   = factor * $urandom_range(0, 4000000);
                modulus = factor * $urandom_range(1, 4000000);
            end
            8: begin
                value   = $urandom >> $urandom_range(0, 31);
                modulus = $urandom >> $urandom_range(0, 31);
            end
            default: begin
                modulus = $urandom;
                value   = $urandom_range(0, 1) ? '0 : modulus;
            end
        endcase
        return operand_pair(value, modulus);
    endfunction

    // Clock.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stimulus, reset and end of run.
    initial begin
        // Zero modulus and zero value corners.
        operand_queue.push_back(operand_pair(32'd0, 32'd0));
        operand_queue.push_back(operand_pair(32'd5, 32'd0));
        operand_queue.push_back(operand_pair(32'hFFFF_FFFF, 32'd0));
        operand_queue.push_back(operand_pair(32'd0, 32'd1));
        operand_queue.push_back(operand_pair(32'd0, 32'd7));
        operand_queue.push_back(operand_pair(32'd0, 32'hFFFF_FFFF));
        // Modulus one, where the coefficient reduces to zero.
        operand_queue.push_back(operand_pair(32'd1, 32'd1));
        operand_queue.push_back(operand_pair(32'd3, 32'd1));
        operand_queue.push_back(operand_pair(32'hFFFF_FFFF, 32'd1));
        // Small invertible cases, value below and above the modulus.
        operand_queue.push_back(operand_pair(32'd3, 32'd7));
        operand_queue.push_back(operand_pair(32'd7, 32'd3));
        operand_queue.push_back(operand_pair(32'd1, 32'hFFFF_FFFF));
        // Common factors.
        operand_queue.push_back(operand_pair(32'd6, 32'd9));
        operand_queue.push_back(operand_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        operand_queue.push_back(operand_pair(32'h8000_0000, 32'h8000_0000));
        operand_queue.push_back(operand_pair(32'hFFFF_FFFE, 32'h8000_0000));
        // Extreme neighbors and a large prime modulus.
        operand_queue.push_back(operand_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE));
        operand_queue.push_back(operand_pair(32'h8000_0000, 32'hFFFF_FFFF));
        operand_queue.push_back(operand_pair(32'd65537, 32'd4294967291));
        // Consecutive Fibonacci numbers give the longest remainder chain.
        operand_queue.push_back(operand_pair(32'd1836311903, 32'd2971215073));
        operand_queue.push_back(operand_pair(32'd2971215073, 32'd1836311903));
        operand_queue.push_back(operand_pair(32'hAAAA_AAAA, 32'h5555_5555));
        repeat (RANDOM_WORDS) operand_queue.push_back(random_operands());

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every word is taken and every result is back.
        do begin
            @(posedge aclk);
        end while (operand_queue.size() != 0 || s_valid || expected_inverses.size() != 0);
        // Allow time for any stray result to show up.
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("modular_inverse_ext_euclid: match");
        end else begin
            $display("modular_inverse_ext_euclid: mismatch");
        end
        $finish;
    end

    // Sender: offers words in bursts separated by random gaps, and records the
    // expected result of each word at the edge where it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= $urandom_range(1, 12);
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_inverses.push_back('{operands: s_data, result: inverse_of(s_data)});
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (operand_queue.size() != 0) begin
                    s_data  <= operand_queue.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        // Roughly a third of bursts run back to back.
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, taken once, so the block fills and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: switches between always ready, coin-flip ready and mostly
    // stalled, each kept for a random stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            pattern_left <= 0;
            pattern_mode <= 0;
        end else begin
            if (pattern_left == 0) begin
                pattern_mode <= $urandom_range(0, 2);
                pattern_left <= $urandom_range(50, 3000);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (pattern_mode)
                0:       m_ready <= (hold_left == 0);
                1:       m_ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
                default: m_ready <= (hold_left == 0) && ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: checks each returned word against the oldest expectation.
    always @(posedge aclk) begin
        inverse_check_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_inverses.size() == 0) begin
                $error("unexpected result word: inverse %0d gcd_result %0d no_inverse %0b",
                       m_data.inverse, m_data.gcd_result, m_data.no_inverse);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = expected_inverses.pop_front();
                if (m_data.inverse !== want.result.inverse ||
                    m_data.gcd_result !== want.result.gcd_result ||
                    m_data.no_inverse !== want.result.no_inverse) begin
                    mismatch_count <= mismatch_count + 1;
                end
                if (m_data.inverse !== want.result.inverse) begin
                    $error("inverse: expected %0d, actual %0d (value %0d, modulus %0d)",
                           want.result.inverse, m_data.inverse,
                           want.operands.value, want.operands.modulus);
                end
                if (m_data.gcd_result !== want.result.gcd_result) begin
                    $error("gcd_result: expected %0d, actual %0d (value %0d, modulus %0d)",
                           want.result.gcd_result, m_data.gcd_result,
                           want.operands.value, want.operands.modulus);
                end
                if (m_data.no_inverse !== want.result.no_inverse) begin
                    $error("no_inverse: expected %0b, actual %0b (value %0d, modulus %0d)",
                           want.result.no_inverse, m_data.no_inverse,
                           want.operands.value, want.operands.modulus);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modular_inverse_ext_euclid: mismatch");
            $finish;
        end
    end

endmodule
